>>> rtl/core/nec_ir_pkg.sv
package nec_ir_pkg;

    localparam int FRAME_BITS = 32;
    localparam int CNT_W      = $clog2(FRAME_BITS);
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int STATUS_W   = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_CAP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_CAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_BELOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_ABOVE    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REPEAT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FRAME  = 2'd2;

    typedef struct packed {
        logic leader_ok;
        logic space_fail;
        logic space_repeat;
        logic bit_one;
    } t_token;

endpackage

>>> rtl/core/nec_ir_pulse_width_decoder.sv
// NEC infrared pulse-width decoder. Each input transaction carries one measured edge interval
// in 0.5 us ticks, with the capture timeout flag in tuser. The decoder checks the leader and
// the following space, reports a repeat code or a failure, or collects a 32-bit frame LSB
// first and reports the low half as the address and the high half as the command. One
// interval is accepted every cycle while the queue has room; a front stage compares the
// interval against the six threshold registers and queues the outcome in a two-entry queue,
// and a back stage takes outcomes from the queue, walks the phase machine and registers the
// result, taking no outcome while a presented result is stalled. The thresholds come up at
// their default values and should only be written while no interval is in flight.
module nec_ir_pulse_width_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // interval_ticks[15:0]
    input  logic        i_s_tuser,   // timed_out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // status[1:0], address[17:2], command[33:18], zero[39:34]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import nec_ir_pkg::*;

    t_token              front_token;
    t_token              back_token;
    logic                push;
    logic                q_ready;
    logic                q_valid;
    logic                q_pop;
    logic [STATUS_W-1:0] status;
    logic [HALF_W-1:0]   address;
    logic [HALF_W-1:0]   command;

    assign o_cfg_ready = 1'b1;

    nec_ir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_ticks     (i_s_tdata),
        .i_timed_out (i_s_tuser),
        .o_push      (push),
        .i_q_ready   (q_ready),
        .o_token     (front_token)
    );

    nec_ir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_token (front_token),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_token (back_token)
    );

    nec_ir_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .o_tok_pop   (q_pop),
        .i_token     (back_token),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_status    (status),
        .o_address   (address),
        .o_command   (command)
    );

    assign o_m_tdata = {6'd0, command, address, status};

endmodule

>>> rtl/core/nec_ir_front.sv
module nec_ir_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [nec_ir_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nec_ir_pkg::TICK_W-1:0]      i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [nec_ir_pkg::TICK_W-1:0]      i_ticks,
    input  logic                               i_timed_out,
    output logic                               o_push,
    input  logic                               i_q_ready,
    output nec_ir_pkg::t_token                 o_token
);
    import nec_ir_pkg::*;

    logic [TICK_W-1:0] r_leader_cap;
    logic [TICK_W-1:0] r_leader_min;
    logic [TICK_W-1:0] r_space_cap;
    logic [TICK_W-1:0] r_space_min;
    logic [TICK_W-1:0] r_repeat_below;
    logic [TICK_W-1:0] r_one_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_cap   <= 16'd20000;
            r_leader_min   <= 16'd16000;
            r_space_cap    <= 16'd9600;
            r_space_min    <= 16'd4000;
            r_repeat_below <= 16'd6000;
            r_one_above    <= 16'd3000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEADER_CAP:   r_leader_cap   <= i_cfg_data;
                CFG_LEADER_MIN:   r_leader_min   <= i_cfg_data;
                CFG_SPACE_CAP:    r_space_cap    <= i_cfg_data;
                CFG_SPACE_MIN:    r_space_min    <= i_cfg_data;
                CFG_REPEAT_BELOW: r_repeat_below <= i_cfg_data;
                CFG_ONE_ABOVE:    r_one_above    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        o_token.leader_ok    = !i_timed_out && (i_ticks < r_leader_cap)
                               && (i_ticks >= r_leader_min);
        o_token.space_fail   = i_timed_out || (i_ticks >= r_space_cap)
                               || (i_ticks < r_space_min);
        o_token.space_repeat = i_ticks < r_repeat_below;
        o_token.bit_one      = i_ticks > r_one_above;
    end

endmodule

>>> rtl/core/nec_ir_queue.sv
module nec_ir_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_ready,
    input  nec_ir_pkg::t_token  i_token,
    output logic                o_valid,
    input  logic                i_pop,
    output nec_ir_pkg::t_token  o_token
);
    import nec_ir_pkg::*;

    t_token             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_token = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/nec_ir_back.sv
module nec_ir_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tok_valid,
    output logic                               o_tok_pop,
    input  nec_ir_pkg::t_token                 i_token,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [nec_ir_pkg::STATUS_W-1:0]    o_status,
    output logic [nec_ir_pkg::HALF_W-1:0]      o_address,
    output logic [nec_ir_pkg::HALF_W-1:0]      o_command
);
    import nec_ir_pkg::*;

    localparam logic [1:0] PH_LEADER = 2'd0;
    localparam logic [1:0] PH_SPACE  = 2'd1;
    localparam logic [1:0] PH_BITS   = 2'd2;

    logic [1:0]            r_phase;
    logic [1:0]            n_phase;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [FRAME_BITS-1:0] r_bits;
    logic [FRAME_BITS-1:0] n_bits;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic [HALF_W-1:0]     r_addr;
    logic [HALF_W-1:0]     n_addr;
    logic [HALF_W-1:0]     r_cmd;
    logic [HALF_W-1:0]     n_cmd;
    logic [WORD_W-1:0]     word;
    logic                  pop;
    logic                  emit;

    assign pop       = i_tok_valid && (!r_out_valid || i_ready);
    assign o_tok_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_address = r_addr;
    assign o_command = r_cmd;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_bits   = r_bits;
        n_status = r_status;
        n_addr   = r_addr;
        n_cmd    = r_cmd;
        emit     = 1'b0;
        word     = '0;
        if (pop) begin
            case (r_phase)
                PH_SPACE: begin
                    n_phase = PH_LEADER;
                    if (i_token.space_fail) begin
                        emit     = 1'b1;
                        n_status = ST_FAIL;
                        n_addr   = '0;
                        n_cmd    = '0;
                    end else if (i_token.space_repeat) begin
                        emit     = 1'b1;
                        n_status = ST_REPEAT;
                        n_addr   = '0;
                        n_cmd    = '0;
                    end else begin
                        n_phase = PH_BITS;
                        n_cnt   = '0;
                        n_bits  = '0;
                    end
                end
                PH_BITS: begin
                    if (i_token.bit_one) begin
                        n_bits[r_cnt] = 1'b1;
                    end
                    if (r_cnt == CNT_W'(FRAME_BITS - 1)) begin
                        word     = WORD_W'(n_bits);
                        emit     = 1'b1;
                        n_phase  = PH_LEADER;
                        n_cnt    = '0;
                        n_status = ST_FRAME;
                        n_addr   = word[HALF_W-1:0];
                        n_cmd    = word[WORD_W-1:HALF_W];
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                default: begin
                    if (i_token.leader_ok) begin
                        n_phase = PH_SPACE;
                    end else begin
                        n_phase  = PH_LEADER;
                        emit     = 1'b1;
                        n_status = ST_FAIL;
                        n_addr   = '0;
                        n_cmd    = '0;
                    end
                end
            endcase
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEADER;
            r_cnt       <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_bits      <= n_bits;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_addr   <= n_addr;
        r_cmd    <= n_cmd;
    end

    a_cnt_only_in_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_phase == PH_BITS))
        else $error("bit count is nonzero outside the bit phase");

    a_last_bit_gives_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_phase == PH_BITS && r_cnt == CNT_W'(FRAME_BITS - 1))
        |=> (r_out_valid && r_status == ST_FRAME && r_phase == PH_LEADER))
        else $error("last bit did not produce a frame result");

    a_short_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_FRAME) |-> (r_addr == '0 && r_cmd == '0))
        else $error("failure or repeat result carries nonzero data");

    a_no_pop_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !pop)
        else $error("token consumed while a result is stalled");

endmodule

>>> verif/nec_ir_pulse_width_decoder_tb.sv
`timescale 1ns / 100ps

module nec_ir_pulse_width_decoder_tb;
    import nec_ir_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        AWAIT_LEADER = 2'd0,
        AWAIT_SPACE  = 2'd1,
        TAKE_BITS    = 2'd2
    } t_ir_phase;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HALF_W-1:0]   address;
        logic [HALF_W-1:0]   command;
    } t_ir_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [TICK_W-1:0] i_s_tdata;
    logic              i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [39:0]       o_m_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [15:0]       i_cfg_data;

    logic [TICK_W-1:0] leader_cap_thr   = 16'd20000;
    logic [TICK_W-1:0] leader_min_thr   = 16'd16000;
    logic [TICK_W-1:0] space_cap_thr    = 16'd9600;
    logic [TICK_W-1:0] space_min_thr    = 16'd4000;
    logic [TICK_W-1:0] repeat_below_thr = 16'd6000;
    logic [TICK_W-1:0] one_above_thr    = 16'd3000;

    t_ir_phase         ir_phase   = AWAIT_LEADER;
    logic [5:0]        bit_count  = '0;
    logic [WORD_W-1:0] frame_bits = '0;

    t_ir_result pending_results[$];
    int         mismatch_count = 0;
    int         intervals_sent = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    nec_ir_pulse_width_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void push_result(input logic [STATUS_W-1:0] status,
                                        input logic [HALF_W-1:0] address,
                                        input logic [HALF_W-1:0] command);
        t_ir_result r;
        r.status  = status;
        r.address = address;
        r.command = command;
        pending_results.push_back(r);
    endfunction

    function automatic void decode_interval(input logic [TICK_W-1:0] ticks, input logic tmo);
        case (ir_phase)
            AWAIT_SPACE: begin
                ir_phase = AWAIT_LEADER;
                if (tmo || ticks >= space_cap_thr || ticks < space_min_thr) begin
                    push_result(ST_FAIL, '0, '0);
                end else if (ticks < repeat_below_thr) begin
                    push_result(ST_REPEAT, '0, '0);
                end else begin
                    ir_phase   = TAKE_BITS;
                    bit_count  = '0;
                    frame_bits = '0;
                end
            end
            TAKE_BITS: begin
                if (ticks > one_above_thr)
                    frame_bits[bit_count[4:0]] = 1'b1;
                bit_count = bit_count + 6'd1;
                if (bit_count >= FRAME_BITS) begin
                    ir_phase  = AWAIT_LEADER;
                    bit_count = '0;
                    push_result(ST_FRAME, frame_bits[HALF_W-1:0], frame_bits[WORD_W-1:HALF_W]);
                end
            end
            default: begin
                ir_phase = AWAIT_LEADER;
                if (tmo || ticks >= leader_cap_thr || ticks < leader_min_thr)
                    push_result(ST_FAIL, '0, '0);
                else
                    ir_phase = AWAIT_SPACE;
            end
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_range(input int lo, input int hi_excl);
        if (hi_excl > lo)
            return TICK_W'($urandom_range(hi_excl - 1, lo));
        return TICK_W'($urandom());
    endfunction

    always @(posedge i_clk) begin : result_check
        t_ir_result got;
        t_ir_result want;
        got.status  = o_m_tdata[1:0];
        got.address = o_m_tdata[17:2];
        got.command = o_m_tdata[33:18];
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected result transaction: status %0d address %h command %h",
                             got.status, got.address, got.command);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.address !== want.address ||
                    got.command !== want.command) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"Mismatch: expected status %0d address %h command %h, ",
                                  "got status %0d address %h command %h"},
                                 want.status, want.address, want.command,
                                 got.status, got.address, got.command);
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_interval(input logic [TICK_W-1:0] ticks, input logic tmo);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ticks;
        i_s_tuser  <= tmo;
        do @(posedge i_clk); while (!o_s_tready);
        decode_interval(ticks, tmo);
        intervals_sent++;
    endtask

    task automatic drain_pipeline();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [TICK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LEADER_CAP:   leader_cap_thr   = value;
            CFG_LEADER_MIN:   leader_min_thr   = value;
            CFG_SPACE_CAP:    space_cap_thr    = value;
            CFG_SPACE_MIN:    space_min_thr    = value;
            CFG_REPEAT_BELOW: repeat_below_thr = value;
            CFG_ONE_ABOVE:    one_above_thr    = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all_thresholds(input int leader_cap, input int leader_min,
                                        input int space_cap, input int space_min,
                                        input int repeat_below, input int one_above);
        drain_pipeline();
        write_threshold(CFG_LEADER_CAP, TICK_W'(leader_cap));
        write_threshold(CFG_LEADER_MIN, TICK_W'(leader_min));
        write_threshold(CFG_SPACE_CAP, TICK_W'(space_cap));
        write_threshold(CFG_SPACE_MIN, TICK_W'(space_min));
        write_threshold(CFG_REPEAT_BELOW, TICK_W'(repeat_below));
        write_threshold(CFG_ONE_ABOVE, TICK_W'(one_above));
    endtask

    task automatic send_good_leader();
        send_interval(pick_range(leader_min_thr, leader_cap_thr), 1'b0);
    endtask

    task automatic send_frame();
        logic [TICK_W-1:0] ticks;
        send_good_leader();
        send_interval(pick_range((space_min_thr > repeat_below_thr) ? space_min_thr
                                 : repeat_below_thr, space_cap_thr), 1'b0);
        repeat (FRAME_BITS) begin
            case ($urandom_range(3))
                0: ticks = one_above_thr;
                1: ticks = (one_above_thr == '1) ? one_above_thr : one_above_thr + 16'd1;
                2: ticks = pick_range(0, one_above_thr + 1);
                default: ticks = pick_range(one_above_thr, 65536);
            endcase
            send_interval(ticks, $urandom_range(9) == 0);
        end
    endtask

    task automatic run_traffic(input int count);
        int start;
        start = intervals_sent;
        while (intervals_sent - start < count) begin
            case ($urandom_range(9))
                0, 1: send_interval(TICK_W'($urandom()), $urandom_range(3) == 0);
                2: begin
                    send_good_leader();
                    send_interval(pick_range(space_min_thr, repeat_below_thr), 1'b0);
                end
                3: begin
                    send_good_leader();
                    if ($urandom_range(1) == 0)
                        send_interval(pick_range(0, space_min_thr), 1'($urandom_range(1)));
                    else
                        send_interval(pick_range(space_cap_thr, 65536),
                                      1'($urandom_range(1)));
                end
                default: send_frame();
            endcase
        end
    endtask

    task automatic test_leader_limits();
        send_interval(leader_min_thr - 16'd1, 1'b0);
        send_interval(leader_min_thr, 1'b1);
        send_interval(leader_cap_thr, 1'b0);
        send_interval(16'h0000, 1'b0);
        send_interval(16'hFFFF, 1'b0);
        send_interval(leader_cap_thr - 16'd1, 1'b0);
        send_interval(repeat_below_thr, 1'b1);
    endtask

    task automatic test_space_limits();
        send_interval(leader_min_thr, 1'b0);
        send_interval(space_min_thr - 16'd1, 1'b0);
        send_interval(leader_min_thr, 1'b0);
        send_interval(space_cap_thr, 1'b0);
        send_interval(leader_min_thr, 1'b0);
        send_interval(repeat_below_thr - 16'd1, 1'b0);
        send_interval(leader_min_thr, 1'b0);
        send_interval(space_min_thr, 1'b0);
    endtask

    task automatic test_frame_bits();
        int i;
        send_interval(leader_min_thr, 1'b0);
        send_interval(repeat_below_thr, 1'b0);
        for (i = 0; i < FRAME_BITS; i++) begin
            case (i % 4)
                0: send_interval(one_above_thr, 1'b0);
                1: send_interval(one_above_thr + 16'd1, 1'b1);
                2: send_interval(16'h0000, 1'b1);
                default: send_interval(16'hFFFF, 1'b0);
            endcase
        end
    endtask

    task automatic test_default_traffic();
        run_traffic(90);
    endtask

    task automatic test_ordered_thresholds();
        int lmin;
        int smin;
        int rbel;
        lmin = $urandom_range(30000, 1000);
        smin = $urandom_range(20000, 500);
        rbel = smin + $urandom_range(5000, 1);
        write_all_thresholds(lmin + $urandom_range(8000, 1), lmin,
                             rbel + $urandom_range(20000, 1), smin, rbel,
                             $urandom_range(65535, 0));
        send_idle_pct  = 75;
        recv_stall_pct = 0;
        run_traffic(90);
    endtask

    task automatic test_random_thresholds();
        write_all_thresholds($urandom_range(65535, 0), $urandom_range(65535, 0),
                             $urandom_range(65535, 0), $urandom_range(65535, 0),
                             $urandom_range(65535, 0), $urandom_range(65535, 0));
        write_threshold(CFG_SPARE_LO, TICK_W'($urandom()));
        write_threshold(CFG_SPARE_HI, TICK_W'($urandom()));
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        run_traffic(90);
    endtask

    task automatic test_extreme_thresholds();
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        write_all_thresholds(65535, 0, 65535, 0, 0, 0);
        run_traffic(30);
        write_all_thresholds(0, 65535, 0, 65535, 65535, 65535);
        run_traffic(10);
        write_all_thresholds(65535, 0, 65535, 0, 65535, 65535);
        run_traffic(25);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_m_tready  <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_leader_limits();
        test_space_limits();
        test_frame_bits();
        test_default_traffic();
        test_ordered_thresholds();
        test_random_thresholds();
        test_extreme_thresholds();

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
